// ===== rtl/core/rmf_pkg.sv =====
// Shared types and constants of the running median filter.
// No dependencies; imported by every module of the block.
package rmf_pkg;

   // Half-width register
   localparam int HW_W = 4;
   localparam logic [HW_W-1:0] HW_RESET = 4'd5;

   // Per-record sample counter, saturating
   localparam int SEEN_W = 6;
   localparam logic [SEEN_W-1:0] SEEN_LIMIT = 6'd63;

   // Commands from the sequencer to every cell of the chain
   typedef struct packed {
      logic shift;   // take a new transaction: shift delay line, load pass, clear counts
      logic count;   // rank step: compare with broadcast, advance pass chain
   } cell_ctrl_type;

endpackage

// ===== rtl/core/rmf_cell.sv =====
// One cell of the window chain: a delay-line tap, a pass register for the
// rank broadcast, and the less-than / less-or-equal counts. Uses rmf_pkg.
module rmf_cell #(
   parameter int SAMPLE_BITS = 24,
   parameter int CNT_W       = 5
) (
   input  logic                      clock,
   input  rmf_pkg::cell_ctrl_type    ctrl,
   input  logic [SAMPLE_BITS-1:0]    shift_in,
   input  logic [SAMPLE_BITS-1:0]    pass_in,
   input  logic [SAMPLE_BITS-1:0]    bcast,
   output logic [SAMPLE_BITS-1:0]    sample_out,
   output logic [SAMPLE_BITS-1:0]    pass_out,
   output logic [CNT_W-1:0]          lt_count,
   output logic [CNT_W-1:0]          le_count
);
   import rmf_pkg::*;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0] pass_ff, pass_in_nxt;
   logic [CNT_W-1:0]       lt_ff, lt_in;
   logic [CNT_W-1:0]       le_ff, le_in;

   // Shift on a new transaction, count against the broadcast on a rank step, otherwise hold
   always_comb begin
      sample_in   = sample_ff;
      pass_in_nxt = pass_ff;
      lt_in       = lt_ff;
      le_in       = le_ff;
      if (ctrl.shift) begin
         sample_in   = shift_in;
         pass_in_nxt = shift_in;
         lt_in       = '0;
         le_in       = '0;
      end else if (ctrl.count) begin
         pass_in_nxt = pass_in;
         if ($signed(bcast) < $signed(sample_ff)) begin
            lt_in = lt_ff + 1'b1;
         end
         if ($signed(bcast) <= $signed(sample_ff)) begin
            le_in = le_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      pass_ff   <= pass_in_nxt;
      lt_ff     <= lt_in;
      le_ff     <= le_in;
   end

   assign sample_out = sample_ff;
   assign pass_out   = pass_ff;
   assign lt_count   = lt_ff;
   assign le_count   = le_ff;

endmodule

// ===== rtl/core/rmf_seq.sv =====
// Sequencer of the running median filter: half-width register, record
// counter, rank-count timing, tail flush and the result register. Uses rmf_pkg.
module rmf_seq #(
   parameter int SAMPLE_BITS    = 24,
   parameter int MAX_HALF_WIDTH = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_last,
   output logic                               req_stall,
   input  logic                               csr_write_en,
   input  logic [rmf_pkg::HW_W-1:0]           csr_write_data,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [SAMPLE_BITS-1:0]             rsp_value,
   output logic                               rsp_is_median,
   output logic                               rsp_end_of_record,
   output rmf_pkg::cell_ctrl_type             cell_ctrl,
   output logic [rmf_pkg::HW_W-1:0]           k_sel,
   output logic [rmf_pkg::HW_W-1:0]           tail_age,
   input  logic [SAMPLE_BITS-1:0]             med_value,
   input  logic [SAMPLE_BITS-1:0]             raw_value,
   input  logic [SAMPLE_BITS-1:0]             tail_value
);
   import rmf_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_COUNT = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;
   localparam logic [1:0] S_TAIL  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [HW_W-1:0]        hw_ff, hw_in;
   logic [SEEN_W-1:0]      seen_ff, seen_in;
   logic [HW_W-1:0]        k_ff, k_in;
   logic [HW_W:0]          cnt_ff, cnt_in;
   logic [HW_W-1:0]        tail_ff, tail_in;
   logic                   last_ff, last_in;
   logic                   med_ff, med_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_med_ff, rsp_med_in;
   logic                   rsp_eor_ff, rsp_eor_in;

   logic                   accept;
   logic                   out_free;
   logic [HW_W-1:0]        k_now;
   logic [SEEN_W:0]        n_now;
   logic [HW_W:0]          win_len;
   logic                   early;
   logic                   full;
   logic [HW_W-1:0]        tail_now;

   assign accept   = (state_ff == S_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Decode the incoming transaction against the record position
   always_comb begin
      if ({1'b0, hw_ff} > 5'(MAX_HALF_WIDTH)) begin
         k_now = HW_W'(MAX_HALF_WIDTH);
      end else begin
         k_now = hw_ff;
      end
      n_now   = {1'b0, seen_ff} + 1'b1;
      win_len = {k_now, 1'b1};
      early   = seen_ff < SEEN_W'(k_now);
      full    = n_now >= (SEEN_W + 1)'(win_len);
      if (!req_last) begin
         tail_now = '0;
      end else if (full) begin
         tail_now = k_now;
      end else if (n_now >= (SEEN_W + 1)'(k_now)) begin
         tail_now = HW_W'(n_now - (SEEN_W + 1)'(k_now));
      end else begin
         tail_now = '0;
      end
   end

   // Next-state logic of the sequencer and the result register
   always_comb begin
      state_in     = state_ff;
      hw_in        = csr_write_en ? csr_write_data : hw_ff;
      seen_in      = seen_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      med_in       = med_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_eor_in   = rsp_eor_ff;
      cell_ctrl    = '{shift: 1'b0, count: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cell_ctrl.shift = 1'b1;
               k_in    = k_now;
               tail_in = tail_now;
               last_in = req_last;
               if (req_last) begin
                  seen_in = '0;
               end else if (seen_ff < SEEN_LIMIT) begin
                  seen_in = seen_ff + 1'b1;
               end
               if (early) begin
                  med_in   = 1'b0;
                  state_in = S_EMIT;
               end else if (full) begin
                  med_in   = 1'b1;
                  cnt_in   = {k_now, 1'b0};
                  state_in = S_COUNT;
               end else if (tail_now != '0) begin
                  state_in = S_TAIL;
               end
            end
         end
         S_COUNT: begin
            cell_ctrl.count = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = med_ff ? med_value : raw_value;
               rsp_med_in   = med_ff;
               rsp_eor_in   = last_ff && (tail_ff == '0);
               state_in     = (tail_ff != '0) ? S_TAIL : S_IDLE;
            end
         end
         S_TAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = tail_value;
               rsp_med_in   = 1'b0;
               rsp_eor_in   = (tail_ff == HW_W'(1));
               tail_in      = tail_ff - 1'b1;
               if (tail_ff == HW_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hw_ff        <= HW_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Transaction payload
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      cnt_ff       <= cnt_in;
      tail_ff      <= tail_in;
      last_ff      <= last_in;
      med_ff       <= med_in;
      rsp_value_ff <= rsp_value_in;
      rsp_med_ff   <= rsp_med_in;
      rsp_eor_ff   <= rsp_eor_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_is_median     = rsp_med_ff;
   assign rsp_end_of_record = rsp_eor_ff;
   assign k_sel             = k_ff;
   assign tail_age          = tail_ff - 1'b1;

endmodule

// ===== rtl/core/running_median_filter.sv =====
// Running median filter: a transaction that yields a median runs accept, 2K+1
// rank-count steps through the cell chain, then emit; a raw early sample runs
// accept then emit, and each flushed tail result follows on its own.
// The rank-count pass over the window sets the rate; one transaction at a time.
// Reset (synchronous) clears the record count, sets K to 5 and empties the
// result register; window contents are not cleared.
module running_median_filter #(
   parameter int MAX_HALF_WIDTH = 15,
   parameter int SAMPLE_BITS    = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [SAMPLE_BITS-1:0]          req_sample,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [SAMPLE_BITS-1:0]          rsp_value,
   output logic                            rsp_is_median,
   output logic                            rsp_end_of_record,
   input  logic                            csr_write_en,
   input  logic [rmf_pkg::HW_W-1:0]        csr_write_data
);
   import rmf_pkg::*;

   localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > HW_W + 1) ? CNT_W : HW_W + 1;

   cell_ctrl_type          cell_ctrl;
   logic [HW_W-1:0]        k_sel;
   logic [HW_W-1:0]        tail_age;
   logic [SAMPLE_BITS-1:0] med_value;
   logic [SAMPLE_BITS-1:0] tail_value;
   logic [SAMPLE_BITS-1:0] cell_sample [DEPTH];
   logic [SAMPLE_BITS-1:0] cell_pass   [DEPTH];
   logic [CNT_W-1:0]       cell_lt     [DEPTH];
   logic [CNT_W-1:0]       cell_le     [DEPTH];

   // Chain of cells: samples move up on a new transaction, pass values move down
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [SAMPLE_BITS-1:0] shift_src;
      logic [SAMPLE_BITS-1:0] pass_src;

      if (g == 0) begin : g_head
         assign shift_src = req_sample;
      end else begin : g_body
         assign shift_src = cell_sample[g-1];
      end

      if (g == DEPTH - 1) begin : g_end
         assign pass_src = '0;
      end else begin : g_mid
         assign pass_src = cell_pass[g+1];
      end

      rmf_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .CNT_W       (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .shift_in   (shift_src),
         .pass_in    (pass_src),
         .bcast      (cell_pass[0]),
         .sample_out (cell_sample[g]),
         .pass_out   (cell_pass[g]),
         .lt_count   (cell_lt[g]),
         .le_count   (cell_le[g])
      );
   end

   // Pick the window cell of rank K; equal-valued matches carry the same value
   always_comb begin
      logic [CMP_W-1:0] k_ext;
      logic [CMP_W-1:0] win_top;
      k_ext     = CMP_W'(k_sel);
      win_top   = CMP_W'({k_sel, 1'b0});
      med_value = '0;
      for (int c = 0; c < DEPTH; c++) begin
         if ((CMP_W'(c) <= win_top) && (CMP_W'(cell_lt[c]) <= k_ext)
             && (k_ext < CMP_W'(cell_le[c]))) begin
            med_value = med_value | cell_sample[c];
         end
      end
   end

   // Read the held tail sample by age
   always_comb begin
      logic [CMP_W-1:0] age_ext;
      age_ext    = CMP_W'(tail_age);
      tail_value = '0;
      for (int c = 0; c < DEPTH; c++) begin
         if (CMP_W'(c) == age_ext) begin
            tail_value = tail_value | cell_sample[c];
         end
      end
   end

   rmf_seq #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_last          (req_last),
      .req_stall         (req_stall),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_value         (rsp_value),
      .rsp_is_median     (rsp_is_median),
      .rsp_end_of_record (rsp_end_of_record),
      .cell_ctrl         (cell_ctrl),
      .k_sel             (k_sel),
      .tail_age          (tail_age),
      .med_value         (med_value),
      .raw_value         (cell_sample[0]),
      .tail_value        (tail_value)
   );

endmodule

// ===== dv/running_median_filter_tb.sv =====
// Self-checking testbench for running_median_filter: drives sample records with
// random idling and stalls and checks every result against a built-in predictor.
// Depends on rmf_pkg and the running_median_filter RTL.
`timescale 1ns / 100ps

module running_median_filter_tb;
   import rmf_pkg::*;

   localparam int MAX_HW        = 15;
   localparam int SAMPLE_W      = 24;
   localparam int LINE_DEPTH    = 2 * MAX_HW + 1;
   localparam int SEEN_MAX      = 63;
   localparam int SETTLE_CYCLES = 64;    // worst transaction: a median then K flushed tail results
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 22;
   localparam int RANDOM_PHASES = 7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                is_last;
   } sample_item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                is_median;
      logic                end_of_record;
   } filter_output_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_value;
   logic                rsp_is_median;
   logic                rsp_end_of_record;
   logic                csr_write_en = 1'b0;
   logic [HW_W-1:0]     csr_write_data = '0;

   // Stimulus and prediction state
   sample_item_type   queued_samples[$];
   filter_output_type pending_filter_outputs[$];
   sample_item_type   next_item;
   logic [SAMPLE_W-1:0] delay_line [LINE_DEPTH];
   int unsigned    seen_count = 0;
   logic [HW_W-1:0] half_width_shadow = HW_RESET;
   logic           req_taken = 1'b0;
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             fail_count = 0;
   int             quiet_cycles = 0;
   logic [SAMPLE_W-1:0] corner_samples [12];

   running_median_filter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_is_median     (rsp_is_median),
      .rsp_end_of_record (rsp_end_of_record),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   // Free-running clock
   initial begin
      forever #1 clock = ~clock;
   end

   // Shift one sample into the delay line and queue the results it causes
   task automatic predict_filter_outputs(input logic [SAMPLE_W-1:0] s, input logic is_last);
      int unsigned k, j, n, first_held;
      int d, p, cnt;
      logic signed [SAMPLE_W-1:0] sorted_win [LINE_DEPTH];
      logic signed [SAMPLE_W-1:0] v;
      filter_output_type res [32];
      k = (half_width_shadow > MAX_HW) ? MAX_HW : half_width_shadow;
      cnt = 0;
      for (d = LINE_DEPTH - 1; d > 0; d--) delay_line[d] = delay_line[d-1];
      delay_line[0] = s;
      j = seen_count;
      n = j + 1;
      if (seen_count < SEEN_MAX) seen_count++;
      if (j < k) begin
         res[cnt] = '{value: s, is_median: 1'b0, end_of_record: 1'b0};
         cnt++;
      end else if (n >= 2 * k + 1) begin
         // insertion sort of the window, signed order
         for (d = 0; d < 2 * k + 1; d++) begin
            v = delay_line[d];
            p = d;
            while (p > 0 && sorted_win[p-1] > v) begin
               sorted_win[p] = sorted_win[p-1];
               p--;
            end
            sorted_win[p] = v;
         end
         res[cnt] = '{value: sorted_win[k], is_median: 1'b1, end_of_record: 1'b0};
         cnt++;
      end
      if (is_last) begin
         // flush the held tail raw, oldest first
         if (n >= 2 * k + 1) first_held = n - k;
         else if (n < k) first_held = n;
         else first_held = k;
         for (d = n - first_held; d > 0; d--) begin
            if (d - 1 < LINE_DEPTH) begin
               res[cnt] = '{value: delay_line[d-1], is_median: 1'b0, end_of_record: 1'b0};
               cnt++;
            end
         end
         if (cnt > 0) res[cnt-1].end_of_record = 1'b1;
         seen_count = 0;
      end
      for (d = 0; d < cnt; d++) pending_filter_outputs.push_back(res[d]);
   endtask

   // Driver: present queued samples, idle at random when the slot is free
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = queued_samples.pop_front();
            req_valid  <= 1'b1;
            req_sample <= next_item.sample;
            req_last   <= next_item.is_last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Monitor: check results in order, predict each accepted sample
   always @(posedge clock) begin
      filter_output_type want;
      req_taken = req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_filter_outputs.size() == 0) begin
               $error("unexpected result: value %0d is_median %0b end_of_record %0b",
                      $signed(rsp_value), rsp_is_median, rsp_end_of_record);
               fail_count++;
            end else begin
               want = pending_filter_outputs.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, got %0d", $signed(want.value),
                         $signed(rsp_value));
                  fail_count++;
               end
               if (rsp_is_median !== want.is_median) begin
                  $error("is_median: expected %0b, got %0b", want.is_median, rsp_is_median);
                  fail_count++;
               end
               if (rsp_end_of_record !== want.end_of_record) begin
                  $error("end_of_record: expected %0b, got %0b", want.end_of_record,
                         rsp_end_of_record);
                  fail_count++;
               end
            end
         end
         if (req_taken) predict_filter_outputs(req_sample, req_last);
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] r;
      r = SAMPLE_W'($urandom);
      case ($urandom_range(3))
         1: r = SAMPLE_W'($urandom_range(8) - 4);           // clustered values, many ties
         2: r = SAMPLE_W'(($urandom_range(1) ? 24'h7FFFFF : 24'h800000) ^ $urandom_range(3));
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_record(input int len, input logic close);
      int i;
      for (i = 0; i < len; i++)
         queued_samples.push_back('{sample: pick_sample(), is_last: close && (i == len - 1)});
   endtask

   // Wait for the block to drain, then let its longest transaction finish
   task automatic settle();
      while (queued_samples.size() != 0 || req_valid || pending_filter_outputs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_half_width(input logic [HW_W-1:0] v);
      settle();
      csr_write_en      <= 1'b1;
      csr_write_data    <= v;
      half_width_shadow = v;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Stimulus sequence
   initial begin
      int ph, k, emitted, len, i;
      for (i = 0; i < LINE_DEPTH; i++) delay_line[i] = '0;
      corner_samples = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
                         24'h7FFFFE, 24'h800001, 24'h555555, 24'hAAAAAA, 24'h000001,
                         24'h7FFFFF, 24'h800000};
      send_idle_pct = 35;
      stall_pct     = 53;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset half-width: corner values, medians plus raw head and tail
      for (i = 0; i < 12; i++)
         queued_samples.push_back('{sample: corner_samples[i], is_last: i == 11});

      // Zero half-width: every sample is its own median
      write_half_width(4'd0);
      queued_samples.push_back('{sample: 24'd123, is_last: 1'b0});
      queued_samples.push_back('{sample: -24'sd5, is_last: 1'b1});
      queued_samples.push_back('{sample: 24'h800000, is_last: 1'b1});

      // Widest window, record shorter than it passes through
      write_half_width(4'd15);
      queue_record(3, 1'b1);
      queue_record(1, 1'b1);

      // Half-width changed in the middle of a record
      write_half_width(4'd1);
      queue_record(3, 1'b0);
      write_half_width(4'd3);
      queue_record(3, 1'b1);

      // Random records over several half-widths and idling profiles
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES / 3) begin
            send_idle_pct = 53;
            stall_pct     = 35;
         end else if (ph == 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         if (ph % 5 == 0) k = MAX_HW;
         else if (ph % 5 == 3) k = 0;
         else k = $urandom_range(MAX_HW);
         write_half_width(k[HW_W-1:0]);
         // one record long enough to saturate the sample count
         if (ph == 6) queue_record(70, 1'b1);
         emitted = 0;
         while (emitted < PHASE_ITEMS) begin
            if ($urandom_range(7) == 0) len = $urandom_range(1, 2 * k + 1);
            else len = $urandom_range(2 * k + 1, 2 * k + 24);
            queue_record(len, 1'b1);
            emitted += len;
         end
         // leave a record open across the next half-width change
         if (ph < RANDOM_PHASES - 1 && $urandom_range(3) == 0)
            queue_record($urandom_range(1, 2 * k + 2), 1'b0);
      end

      settle();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/rmf_pkg.sv
rtl/core/rmf_cell.sv
rtl/core/rmf_seq.sv
rtl/core/running_median_filter.sv
dv/running_median_filter_tb.sv
